@@ sv/dimg_pkg.sv @@
// shared types and constants for the disk image block decompressor
package dimg_pkg;

    localparam int BUF_BYTES = 256;
    localparam int BUF_AW    = 8;

    localparam logic [7:0] BK_HDR_A   = 8'hF9;
    localparam logic [7:0] BK_HDR_B   = 8'hFA;
    localparam logic [7:0] BK_END     = 8'h45;
    localparam logic [6:0] BK_PREFIX  = 7'h41;
    localparam logic [6:0] BK_SEGMENT = 7'h43;
    localparam logic [6:0] BK_TAIL    = 7'h44;
    localparam logic [6:0] BK_SAME    = 7'h46;
    localparam logic [6:0] BK_RAW     = 7'h47;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_FIRST     = 3'd1;
    localparam logic [2:0] ERR_UNENDED   = 3'd2;
    localparam logic [2:0] ERR_DENSITY   = 3'd3;
    localparam logic [2:0] ERR_BLOCK     = 3'd4;
    localparam logic [2:0] ERR_SECTOR0   = 3'd5;

    typedef enum logic [4:0] {
        PH_ARCHIVE, PH_BLOCK, PH_DENS, PH_SEC_LO, PH_SEC_HI, PH_PRE_OFF, PH_PRE_FILL,
        PH_PRE_LIT, PH_SEG_FIRST, PH_SEG_LIT, PH_SEG_RUNEND, PH_SEG_FILL,
        PH_SEG_LITEND, PH_TAIL_OFF, PH_TAIL_LIT, PH_RAW, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {E_FILL, E_PARSE, E_WAIT, E_HALT} eng_t;

    typedef enum logic [2:0] {U_IDLE, U_READ, U_LAST, U_EMIT, U_STATUS} unl_t;

    typedef struct packed {
        logic        start;
        logic        status;
        logic [1:0]  kind;
        logic [2:0]  code;
        logic [15:0] sector;
        logic [23:0] base;
        logic        long_sec;
    } unl_req_t;

endpackage

@@ sv/dimg_ram.sv @@
// generic single write, single read ram with registered read
module dimg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ sv/dimg_parser.sv @@
// archive byte parser, buffer fill engine and sector dump requests
module dimg_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic                      cfg_write_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                data_byte,
    input  logic                      dump_done,
    output dimg_pkg::unl_req_t        req,
    output logic                      mem_we,
    output logic [dimg_pkg::BUF_AW-1:0] mem_addr,
    output logic [7:0]                mem_data
);
    import dimg_pkg::*;

    eng_t        eng_reg, eng_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  blk_reg, blk_next;
    logic        long_reg, long_next;
    logic        last_reg, last_next;
    logic        open_reg, open_next;
    logic [15:0] sec_reg, sec_next;
    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  re_reg, re_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  fill_reg, fill_next;
    logic [8:0]  fcnt_reg, fcnt_next;
    logic [8:0]  fend_reg, fend_next;
    logic        fdump_reg, fdump_next;
    logic        hdr_reg;

    logic        accept, dump, fail, done_st;
    logic [2:0]  fail_code;
    logic [8:0]  dens, seclen, offs, pos_inc, pos_max;
    logic [15:0] sec_m4;
    logic [23:0] base;

    assign accept  = in_valid && in_ready;
    assign dens    = long_reg ? 9'd256 : 9'd128;
    assign seclen  = (sec_reg < 16'd4) ? 9'd128 : dens;
    assign offs    = (data_byte == 8'd0) ? 9'd256 : {1'b0, data_byte};
    assign pos_inc = pos_reg + 9'd1;
    assign pos_max = (pos_reg < re_reg) ? re_reg : pos_reg;
    assign sec_m4  = sec_reg - 16'd4;

    always_comb
    begin
        if (sec_reg < 16'd4)
        begin
            base = {15'd0, sec_reg[1:0] - 2'd1, 7'd0};
        end
        else if (long_reg)
        begin
            base = {sec_m4, 8'd0} + 24'd384;
        end
        else
        begin
            base = {1'b0, sec_m4, 7'd0} + 24'd384;
        end
        if (hdr_reg)
        begin
            base = base + 24'd16;
        end
    end

    always_comb
    begin
        eng_next   = eng_reg;
        phase_next = phase_reg;
        blk_next   = blk_reg;
        long_next  = long_reg;
        last_next  = last_reg;
        open_next  = open_reg;
        sec_next   = sec_reg;
        pos_next   = pos_reg;
        re_next    = re_reg;
        hold_next  = hold_reg;
        fill_next  = fill_reg;
        fcnt_next  = fcnt_reg;
        fend_next  = fend_reg;
        fdump_next = fdump_reg;
        dump       = 1'b0;
        fail       = 1'b0;
        fail_code  = ERR_NONE;
        done_st    = 1'b0;
        req        = '0;
        unique case (eng_reg)
            E_FILL:
            begin
                fcnt_next = fcnt_reg + 9'd1;
                if (fcnt_next == fend_reg)
                begin
                    if (fdump_reg)
                    begin
                        dump = 1'b1;
                    end
                    else
                    begin
                        eng_next = E_PARSE;
                    end
                end
            end
            E_WAIT:
            begin
                if (dump_done)
                begin
                    eng_next = E_PARSE;
                end
            end
            E_HALT:
            begin
            end
            E_PARSE:
            begin
                if (accept)
                begin
                    unique case (phase_reg)
                        PH_ARCHIVE:
                        begin
                            if (data_byte != BK_HDR_A && data_byte != BK_HDR_B)
                            begin
                                fail = 1'b1;
                                fail_code = ERR_FIRST;
                            end
                            else
                            begin
                                blk_next = data_byte;
                                phase_next = PH_DENS;
                            end
                        end
                        PH_BLOCK:
                        begin
                            blk_next = data_byte;
                            if (data_byte == BK_HDR_A || data_byte == BK_HDR_B)
                            begin
                                if (open_reg)
                                begin
                                    fail = 1'b1;
                                    fail_code = ERR_UNENDED;
                                end
                                else
                                begin
                                    phase_next = PH_DENS;
                                end
                            end
                            else if (data_byte == BK_END)
                            begin
                                open_next = 1'b0;
                                if (last_reg)
                                begin
                                    phase_next = PH_DONE;
                                    done_st = 1'b1;
                                end
                            end
                            else if (data_byte[6:0] == BK_PREFIX)
                            begin
                                phase_next = PH_PRE_OFF;
                            end
                            else if (data_byte[6:0] == BK_SEGMENT)
                            begin
                                pos_next = 9'd0;
                                phase_next = PH_SEG_FIRST;
                            end
                            else if (data_byte[6:0] == BK_TAIL)
                            begin
                                phase_next = PH_TAIL_OFF;
                            end
                            else if (data_byte[6:0] == BK_SAME)
                            begin
                                dump = 1'b1;
                            end
                            else if (data_byte[6:0] == BK_RAW)
                            begin
                                pos_next = 9'd0;
                                re_next = seclen;
                                phase_next = PH_RAW;
                            end
                            else
                            begin
                                fail = 1'b1;
                                fail_code = ERR_BLOCK;
                            end
                        end
                        PH_DENS:
                        begin
                            last_next = data_byte[7];
                            phase_next = PH_SEC_LO;
                            if (data_byte[6:4] == 3'd0 || data_byte[6:4] == 3'd4)
                            begin
                                long_next = 1'b0;
                            end
                            else if (data_byte[6:4] == 3'd2)
                            begin
                                long_next = 1'b1;
                            end
                            else
                            begin
                                fail = 1'b1;
                                fail_code = ERR_DENSITY;
                            end
                        end
                        PH_SEC_LO:
                        begin
                            hold_next = data_byte;
                            phase_next = PH_SEC_HI;
                        end
                        PH_SEC_HI:
                        begin
                            sec_next = {data_byte, hold_reg};
                            if (blk_reg == BK_HDR_A || blk_reg == BK_HDR_B)
                            begin
                                open_next = 1'b1;
                            end
                            phase_next = PH_BLOCK;
                        end
                        PH_PRE_OFF:
                        begin
                            re_next = offs;
                            phase_next = PH_PRE_FILL;
                        end
                        PH_PRE_FILL:
                        begin
                            fill_next = data_byte;
                            pos_next = re_reg;
                            phase_next = PH_PRE_LIT;
                            fcnt_next = 9'd0;
                            fend_next = dens;
                            fdump_next = 1'b0;
                            eng_next = E_FILL;
                        end
                        PH_PRE_LIT:
                        begin
                            pos_next = pos_reg - 9'd1;
                            if (pos_next == 9'd0)
                            begin
                                dump = 1'b1;
                            end
                        end
                        PH_SEG_FIRST, PH_SEG_LITEND:
                        begin
                            re_next = (phase_reg == PH_SEG_FIRST) ? {1'b0, data_byte} : offs;
                            if (pos_reg < re_next)
                            begin
                                phase_next = PH_SEG_LIT;
                            end
                            else if (pos_reg == dens)
                            begin
                                dump = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_SEG_RUNEND;
                            end
                        end
                        PH_SEG_LIT:
                        begin
                            pos_next = pos_inc;
                            if (pos_inc >= re_reg)
                            begin
                                if (pos_inc == dens)
                                begin
                                    dump = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_SEG_RUNEND;
                                end
                            end
                        end
                        PH_SEG_RUNEND:
                        begin
                            re_next = offs;
                            phase_next = PH_SEG_FILL;
                        end
                        PH_SEG_FILL:
                        begin
                            fill_next = data_byte;
                            pos_next = pos_max;
                            phase_next = PH_SEG_LITEND;
                            if (pos_reg < re_reg)
                            begin
                                fcnt_next = pos_reg;
                                fend_next = re_reg;
                                fdump_next = (pos_max >= dens);
                                eng_next = E_FILL;
                            end
                            else if (pos_max >= dens)
                            begin
                                dump = 1'b1;
                            end
                        end
                        PH_TAIL_OFF:
                        begin
                            pos_next = offs;
                            if (offs < dens)
                            begin
                                phase_next = PH_TAIL_LIT;
                            end
                            else
                            begin
                                dump = 1'b1;
                            end
                        end
                        PH_TAIL_LIT:
                        begin
                            pos_next = pos_inc;
                            if (pos_inc >= dens)
                            begin
                                dump = 1'b1;
                            end
                        end
                        PH_RAW:
                        begin
                            pos_next = pos_inc;
                            if (pos_inc >= re_reg)
                            begin
                                dump = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        if (dump)
        begin
            if (sec_reg == 16'd0)
            begin
                fail = 1'b1;
                fail_code = ERR_SECTOR0;
            end
            else
            begin
                req.start    = 1'b1;
                req.sector   = sec_reg;
                req.base     = base;
                req.long_sec = (sec_reg >= 16'd4) && long_reg;
                sec_next     = blk_next[7] ? sec_reg + 16'd1 : sec_reg;
                phase_next   = blk_next[7] ? PH_BLOCK : PH_SEC_LO;
                eng_next     = E_WAIT;
            end
        end
        if (fail || done_st)
        begin
            req.status = 1'b1;
            req.kind   = fail ? KIND_ERROR : KIND_DONE;
            req.code   = fail_code;
            eng_next   = E_HALT;
        end
    end

    always_comb
    begin
        in_ready = (eng_reg == E_PARSE) || (eng_reg == E_HALT);
        mem_we   = 1'b0;
        mem_addr = pos_reg[BUF_AW-1:0];
        mem_data = data_byte;
        if (eng_reg == E_FILL)
        begin
            mem_we   = 1'b1;
            mem_addr = fcnt_reg[BUF_AW-1:0];
            mem_data = fill_reg;
        end
        else if (eng_reg == E_PARSE && in_valid)
        begin
            if (phase_reg == PH_PRE_LIT)
            begin
                mem_we   = 1'b1;
                mem_addr = pos_reg[BUF_AW-1:0] - 8'd1;
            end
            else if (phase_reg == PH_SEG_LIT || phase_reg == PH_TAIL_LIT
                     || phase_reg == PH_RAW)
            begin
                mem_we = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg   <= E_FILL;
            phase_reg <= PH_ARCHIVE;
            blk_reg   <= 8'd0;
            long_reg  <= 1'b0;
            last_reg  <= 1'b0;
            open_reg  <= 1'b0;
            sec_reg   <= 16'd0;
            pos_reg   <= 9'd0;
            re_reg    <= 9'd0;
            hold_reg  <= 8'd0;
            fill_reg  <= 8'd0;
            fcnt_reg  <= 9'd0;
            fend_reg  <= 9'd256;
            fdump_reg <= 1'b0;
            hdr_reg   <= 1'b1;
        end
        else
        begin
            eng_reg   <= eng_next;
            phase_reg <= phase_next;
            blk_reg   <= blk_next;
            long_reg  <= long_next;
            last_reg  <= last_next;
            open_reg  <= open_next;
            sec_reg   <= sec_next;
            pos_reg   <= pos_next;
            re_reg    <= re_next;
            hold_reg  <= hold_next;
            fill_reg  <= fill_next;
            fcnt_reg  <= fcnt_next;
            fend_reg  <= fend_next;
            fdump_reg <= fdump_next;
            if (cfg_write_en)
            begin
                hdr_reg <= cfg_write_data;
            end
        end
    end
endmodule

@@ sv/dimg_unload.sv @@
// sector dump reader and output word register
module dimg_unload (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dimg_pkg::unl_req_t          req,
    output logic                        dump_done,
    output logic [dimg_pkg::BUF_AW-1:0] rd_addr,
    input  logic [7:0]                  rd_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [2:0]                  error_code,
    output logic [15:0]                 sector,
    output logic [23:0]                 image_address,
    output logic [4:0]                  word_index,
    output logic [63:0]                 data,
    output logic                        last_word
);
    import dimg_pkg::*;

    unl_t        st_reg, st_next;
    logic [8:0]  bcnt_reg;
    logic [4:0]  word_reg;
    logic        pend_reg;
    logic [2:0]  lane_reg;
    logic [63:0] wbuf_reg;
    logic [15:0] sec_reg;
    logic [23:0] base_reg;
    logic        long_reg;
    logic [1:0]  skind_reg;
    logic [2:0]  scode_reg;
    logic        ov_reg;
    logic        slot_free, at_end;

    assign slot_free = !ov_reg || out_ready;
    assign at_end    = bcnt_reg == (long_reg ? 9'd256 : 9'd128);
    assign rd_addr   = bcnt_reg[BUF_AW-1:0];
    assign out_valid = ov_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    st_next = U_READ;
                end
                else if (req.status)
                begin
                    st_next = U_STATUS;
                end
            end
            U_READ:
            begin
                if (bcnt_reg[2:0] == 3'd7)
                begin
                    st_next = U_LAST;
                end
            end
            U_LAST:
            begin
                st_next = U_EMIT;
            end
            U_EMIT:
            begin
                if (slot_free)
                begin
                    st_next = at_end ? U_IDLE : U_READ;
                end
            end
            U_STATUS:
            begin
                if (slot_free)
                begin
                    st_next = U_IDLE;
                end
            end
            default:
            begin
                st_next = U_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dump_done = (st_reg == U_EMIT) && slot_free && at_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= U_IDLE;
            ov_reg   <= 1'b0;
            pend_reg <= 1'b0;
            bcnt_reg <= 9'd0;
            word_reg <= 5'd0;
        end
        else
        begin
            st_reg   <= st_next;
            pend_reg <= (st_reg == U_READ);
            if ((st_reg == U_EMIT || st_reg == U_STATUS) && slot_free)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
            if (st_reg == U_IDLE && req.start)
            begin
                bcnt_reg <= 9'd0;
                word_reg <= 5'd0;
            end
            if (st_reg == U_READ)
            begin
                bcnt_reg <= bcnt_reg + 9'd1;
            end
            if (st_reg == U_EMIT && slot_free)
            begin
                word_reg <= word_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= bcnt_reg[2:0];
        if (pend_reg)
        begin
            wbuf_reg[lane_reg*8 +: 8] <= rd_data;
        end
        if (st_reg == U_IDLE && (req.start || req.status))
        begin
            sec_reg   <= req.sector;
            base_reg  <= req.base;
            long_reg  <= req.long_sec;
            skind_reg <= req.kind;
            scode_reg <= req.code;
        end
        if (st_reg == U_EMIT && slot_free)
        begin
            kind          <= KIND_DATA;
            error_code    <= ERR_NONE;
            sector        <= sec_reg;
            image_address <= base_reg + {16'd0, word_reg, 3'd0};
            word_index    <= word_reg;
            data          <= wbuf_reg;
            last_word     <= at_end;
        end
        else if (st_reg == U_STATUS && slot_free)
        begin
            kind          <= skind_reg;
            error_code    <= scode_reg;
            sector        <= 16'd0;
            image_address <= 24'd0;
            word_index    <= 5'd0;
            data          <= 64'd0;
            last_word     <= 1'b1;
        end
    end
endmodule

@@ sv/disk_image_block_decompressor.sv @@
// top level of the disk image block decompressor
// Takes one archive byte per cycle while parsing. After reset a clearing pass writes zero to
// every byte of the sector buffer before the first byte is taken. A prefix fill (128 or 256
// bytes) and a run fill both go through the single write port of the buffer ram. A finished
// sector is unloaded through the one read port as 64-bit words (16 or 32 words), during which
// no input is taken. Errors and the end of the archive give one status word, after which all
// input is taken and ignored until reset.
module disk_image_block_decompressor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [2:0]  error_code,
    output logic [15:0] sector,
    output logic [23:0] image_address,
    output logic [4:0]  word_index,
    output logic [63:0] data,
    output logic        last_word
);
    import dimg_pkg::*;

    unl_req_t          req;
    logic              dump_done;
    logic              mem_we;
    logic [BUF_AW-1:0] mem_addr;
    logic [7:0]        mem_data;
    logic [BUF_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    dimg_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .dump_done      (dump_done),
        .req            (req),
        .mem_we         (mem_we),
        .mem_addr       (mem_addr),
        .mem_data       (mem_data)
    );

    dimg_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_buf (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_addr),
        .wr_data (mem_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dimg_unload u_unload (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .dump_done     (dump_done),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .error_code    (error_code),
        .sector        (sector),
        .image_address (image_address),
        .word_index    (word_index),
        .data          (data),
        .last_word     (last_word)
    );
endmodule

@@ sv/dimg_checker.sv @@
// port level checks for the disk image block decompressor
module dimg_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [2:0]  error_code,
    input logic [23:0] image_address,
    input logic [63:0] data,
    input logic        last_word
);
    import dimg_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data) && $stable(kind))
        else $error("output word changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> last_word && data == 64'd0)
        else $error("status word malformed");

    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DATA |-> image_address[2:0] == 3'd0 && error_code == ERR_NONE)
        else $error("data word misaligned or flagged");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DONE |-> error_code == ERR_NONE)
        else $error("completion carries an error code");
endmodule

bind disk_image_block_decompressor dimg_port_checks u_dimg_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .error_code    (error_code),
    .image_address (image_address),
    .data          (data),
    .last_word     (last_word)
);
